@@ rtl/nrmc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the NMEA RMC sentence parser.
package nrmc_pkg;

	localparam int FRAC_DIGITS_DEF = 4;
	localparam int FRAC_W_MAX = 20;
	localparam int RES_DEPTH = 4;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_W = 8'h57;

	localparam logic [19:0] INT_SAT = 20'd999999;
	localparam logic [26:0] LAT_SAT = 27'd100000000;
	localparam logic [29:0] LON_SAT = 30'd1000000000;
	localparam logic [19:0] SPEED_SAT = 20'd999999;
	localparam logic [16:0] HEAD_SAT = 17'd99999;

	localparam logic [3:0] FIELD_TAG = 4'd0;
	localparam logic [3:0] FIELD_TIME = 4'd1;
	localparam logic [3:0] FIELD_LAT = 4'd3;
	localparam logic [3:0] FIELD_NS = 4'd4;
	localparam logic [3:0] FIELD_LON = 4'd5;
	localparam logic [3:0] FIELD_EW = 4'd6;
	localparam logic [3:0] FIELD_SPEED = 4'd7;
	localparam logic [3:0] FIELD_COURSE = 4'd8;
	localparam logic [3:0] FIELD_MAX = 4'd15;
	localparam logic [3:0] RMC_MIN_FIELDS = 4'd9;
	localparam logic [2:0] TAG_LEN = 3'd6;

	// Division of the integer accumulator by one hundred by reciprocal multiplication.
	localparam int DEG_SH = 27;
	localparam logic [20:0] DEG_MAG = 21'd1342178;

	typedef enum logic [1:0] {
		STYPE_UNKNOWN = 2'd0,
		STYPE_GGA = 2'd1,
		STYPE_RMC = 2'd2
	} stype_t;

	typedef struct packed {
		logic lf;
		logic [3:0] fidx;
		logic [19:0] int_v;
		logic [FRAC_W_MAX-1:0] frac;
		logic [2:0] fcnt;
		logic [9:0] millis;
		logic [6:0] centi;
		stype_t stype;
		logic filled;
		logic s_neg;
		logic w_neg;
	} event_t;

	typedef struct packed {
		logic [16:0] heading_centi;
		logic [19:0] speed_centi;
		logic signed [30:0] lon_micro_deg;
		logic signed [27:0] lat_micro_deg;
		logic [9:0] utc_millis;
		logic [19:0] utc_hhmmss;
		logic fields_filled;
		stype_t sentence_type;
	} rslt_t;

	localparam int RES_W = $bits(rslt_t);
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	function automatic longint unsigned pow10(input int n);
		longint unsigned r;
		r = 1;
		for (int i = 0; i < n; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

	function automatic logic [19:0] pow10_20(input logic [2:0] n);
		logic [19:0] r;
		case (n)
			3'd0: r = 20'd1;
			3'd1: r = 20'd10;
			3'd2: r = 20'd100;
			3'd3: r = 20'd1000;
			3'd4: r = 20'd10000;
			3'd5: r = 20'd100000;
			3'd6: r = 20'd1000000;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] tag_rmc(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h24;
			3'd1: c = 8'h47;
			3'd2: c = 8'h50;
			3'd3: c = 8'h52;
			3'd4: c = 8'h4D;
			3'd5: c = 8'h43;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] tag_gga(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h24;
			3'd1: c = 8'h47;
			3'd2: c = 8'h50;
			3'd3: c = 8'h47;
			3'd4: c = 8'h47;
			3'd5: c = 8'h41;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/nrmc_scan.sv @@
`timescale 1ns / 1ps
// Byte scanner: registers each byte, tracks the running line state and issues field events.
module nrmc_scan #(
	parameter int FRAC_DIGITS = nrmc_pkg::FRAC_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        in_char,
	output logic              ev_valid,
	output nrmc_pkg::event_t  ev
);

	localparam int FW = $clog2(nrmc_pkg::pow10(FRAC_DIGITS));
	localparam int CW = $clog2(FRAC_DIGITS + 1);

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic [3:0]        field_count_q;
	logic [2:0]        tmatch_q;
	logic              rmc_ok_q;
	logic              gga_ok_q;
	logic [19:0]       int_q;
	logic [FW-1:0]     frac_q;
	logic [CW-1:0]     fcnt_q;
	logic              point_q;
	logic              stop_q;
	logic [9:0]        p3_q;
	logic [6:0]        p2_q;
	logic [1:0]        flen_q;
	logic [7:0]        first_q;
	logic              s_neg_q;
	logic              w_neg_q;
	logic              ev_valid_s2;
	nrmc_pkg::event_t  ev_s2;

	logic              is_comma;
	logic              is_lf;
	logic              is_digit;
	logic [3:0]        dig;
	logic [23:0]       int_mul;
	logic [19:0]       int_next;
	logic [FW-1:0]     frac_next;
	logic [9:0]        p3_next;
	logic [6:0]        p2_next;
	logic [2:0]        fc3;
	logic              is_s;
	logic              is_w;
	logic              has_tok;
	logic              tok_ge9;
	nrmc_pkg::event_t  ev_d;

	always_comb begin
		is_comma = char_s1 == nrmc_pkg::CH_COMMA;
		is_lf = char_s1 == nrmc_pkg::CH_LF;
		is_digit = (char_s1 >= nrmc_pkg::CH_ZERO) && (char_s1 <= nrmc_pkg::CH_NINE);
		dig = 4'(char_s1 - nrmc_pkg::CH_ZERO);
		int_mul = 24'(int_q) * 24'd10 + 24'(dig);
		int_next = (int_mul > 24'(nrmc_pkg::INT_SAT)) ? nrmc_pkg::INT_SAT : int_mul[19:0];
		frac_next = frac_q * FW'(10) + FW'(dig);
		p3_next = p3_q * 10'd10 + 10'(dig);
		p2_next = p2_q * 7'd10 + 7'(dig);
		fc3 = 3'(fcnt_q);
		is_s = (flen_q == 2'd1) && (first_q == nrmc_pkg::CH_S);
		is_w = (flen_q == 2'd1) && (first_q == nrmc_pkg::CH_W);
		has_tok = (field_count_q != 4'd0) || (flen_q != 2'd0);
		tok_ge9 = (field_count_q >= nrmc_pkg::RMC_MIN_FIELDS)
			|| ((field_count_q == nrmc_pkg::RMC_MIN_FIELDS - 4'd1) && (flen_q != 2'd0));

		ev_d.lf = is_lf;
		ev_d.fidx = field_count_q;
		ev_d.int_v = int_q;
		ev_d.frac = nrmc_pkg::FRAC_W_MAX'(frac_q);
		ev_d.fcnt = fc3;
		case (fc3)
			3'd0: ev_d.millis = 10'd0;
			3'd1: ev_d.millis = p3_q * 10'd100;
			3'd2: ev_d.millis = p3_q * 10'd10;
			default: ev_d.millis = p3_q;
		endcase
		case (fc3)
			3'd0: ev_d.centi = 7'd0;
			3'd1: ev_d.centi = p2_q * 7'd10;
			default: ev_d.centi = p2_q;
		endcase
		if (has_tok && (tmatch_q == nrmc_pkg::TAG_LEN) && rmc_ok_q) begin
			ev_d.stype = nrmc_pkg::STYPE_RMC;
		end else if (has_tok && (tmatch_q == nrmc_pkg::TAG_LEN) && gga_ok_q) begin
			ev_d.stype = nrmc_pkg::STYPE_GGA;
		end else begin
			ev_d.stype = nrmc_pkg::STYPE_UNKNOWN;
		end
		ev_d.filled = (ev_d.stype == nrmc_pkg::STYPE_RMC) && tok_ge9;
		ev_d.s_neg = s_neg_q || ((field_count_q == nrmc_pkg::FIELD_NS) && is_s);
		ev_d.w_neg = w_neg_q || ((field_count_q == nrmc_pkg::FIELD_EW) && is_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ev_valid_s2 <= 1'b0;
			field_count_q <= 4'd0;
			tmatch_q <= 3'd0;
			rmc_ok_q <= 1'b1;
			gga_ok_q <= 1'b1;
			int_q <= 20'd0;
			frac_q <= '0;
			fcnt_q <= '0;
			point_q <= 1'b0;
			stop_q <= 1'b0;
			p3_q <= 10'd0;
			p2_q <= 7'd0;
			flen_q <= 2'd0;
			first_q <= 8'd0;
			s_neg_q <= 1'b0;
			w_neg_q <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			ev_valid_s2 <= valid_s1 && (is_comma || is_lf);
			if (valid_s1) begin
				if (is_comma || is_lf) begin
					int_q <= 20'd0;
					frac_q <= '0;
					fcnt_q <= '0;
					point_q <= 1'b0;
					stop_q <= 1'b0;
					p3_q <= 10'd0;
					p2_q <= 7'd0;
					flen_q <= 2'd0;
					first_q <= 8'd0;
				end
				if (is_comma) begin
					if (field_count_q != nrmc_pkg::FIELD_MAX) begin
						field_count_q <= field_count_q + 4'd1;
					end
					s_neg_q <= ev_d.s_neg;
					w_neg_q <= ev_d.w_neg;
				end else if (is_lf) begin
					field_count_q <= 4'd0;
					tmatch_q <= 3'd0;
					rmc_ok_q <= 1'b1;
					gga_ok_q <= 1'b1;
					s_neg_q <= 1'b0;
					w_neg_q <= 1'b0;
				end else begin
					if (flen_q == 2'd0) begin
						first_q <= char_s1;
					end
					if (flen_q != 2'd2) begin
						flen_q <= flen_q + 2'd1;
					end
					if (field_count_q == nrmc_pkg::FIELD_TAG) begin
						if (tmatch_q < nrmc_pkg::TAG_LEN) begin
							if (char_s1 != nrmc_pkg::tag_rmc(tmatch_q)) begin
								rmc_ok_q <= 1'b0;
							end
							if (char_s1 != nrmc_pkg::tag_gga(tmatch_q)) begin
								gga_ok_q <= 1'b0;
							end
						end
						if (tmatch_q != 3'd7) begin
							tmatch_q <= tmatch_q + 3'd1;
						end
					end
					if (!stop_q) begin
						if (is_digit) begin
							if (!point_q) begin
								int_q <= int_next;
							end else if (fcnt_q < CW'(FRAC_DIGITS)) begin
								frac_q <= frac_next;
								fcnt_q <= fcnt_q + CW'(1);
								if (fc3 < 3'd3) begin
									p3_q <= p3_next;
								end
								if (fc3 < 3'd2) begin
									p2_q <= p2_next;
								end
							end
						end else if ((char_s1 == nrmc_pkg::CH_POINT) && !point_q) begin
							point_q <= 1'b1;
						end else begin
							stop_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		char_s1 <= in_char;
		ev_s2 <= ev_d;
	end

	assign ev_valid = ev_valid_s2;
	assign ev = ev_s2;

endmodule

@@ rtl/nrmc_conv.sv @@
`timescale 1ns / 1ps
// Conversion pipeline: turns field events into coordinates, speed and course, and builds results.
module nrmc_conv #(
	parameter int FRAC_DIGITS = nrmc_pkg::FRAC_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ev_valid,
	input  nrmc_pkg::event_t  ev,
	output logic              res_valid,
	output nrmc_pkg::rslt_t   res
);

	localparam int FPW = nrmc_pkg::FRAC_W_MAX;
	localparam int AW = 27;
	localparam longint unsigned P10F = nrmc_pkg::pow10(FRAC_DIGITS);
	localparam longint unsigned SCALE = (FRAC_DIGITS >= 6) ? 1 : nrmc_pkg::pow10(5 - FRAC_DIGITS);
	localparam longint unsigned DIV = (FRAC_DIGITS >= 6) ? 60 : 6;
	localparam int DL = (FRAC_DIGITS >= 6) ? 6 : 3;
	localparam int SH = AW + DL;
	localparam longint unsigned MAG = ((64'd1 << SH) + DIV - 1) / DIV;
	localparam int MW = $clog2(MAG + 1);
	localparam int QW = AW - 2;

	logic              v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	nrmc_pkg::event_t  ev_s3, ev_s4, ev_s5, ev_s6, ev_s7, ev_s8;
	logic [FPW-1:0]    fpad_s3, fpad_s4, fpad_s5;
	logic [13:0]       deg_s4, deg_s5;
	logic [6:0]        mm_s5;
	logic [19:0]       spd_s5, spd_s6, spd_s7, spd_s8;
	logic [16:0]       hdg_s5, hdg_s6, hdg_s7, hdg_s8;
	logic [AW-1:0]     a_s6;
	logic [33:0]       dege6_s6, dege6_s7;
	logic [QW-1:0]     q_s7;
	logic [26:0]       lat_s8;
	logic [29:0]       lon_s8;

	logic [19:0]       tint_q, tint_n;
	logic [9:0]        tms_q, tms_n;
	logic [26:0]       lat_q, lat_n;
	logic [29:0]       lon_q, lon_n;
	logic [19:0]       spd_q, spd_n;
	logic [16:0]       hdg_q, hdg_n;

	logic [26:0]       spd_raw;
	logic [40:0]       deg_prod;
	logic [AW+MW-1:0]  q_prod;
	logic [33:0]       v_sum;

	always_comb begin
		spd_raw = 27'(ev_s4.int_v) * 27'd100 + 27'(ev_s4.centi);
		deg_prod = 41'(ev_s3.int_v) * 41'(nrmc_pkg::DEG_MAG);
		q_prod = (AW + MW)'(a_s6) * (AW + MW)'(MAG);
		v_sum = dege6_s7 + 34'(q_s7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s3 <= ev_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		ev_s3 <= ev;
		fpad_s3 <= FPW'(ev.frac * nrmc_pkg::pow10_20(3'(FRAC_DIGITS) - ev.fcnt));

		ev_s4 <= ev_s3;
		fpad_s4 <= fpad_s3;
		deg_s4 <= 14'(deg_prod >> nrmc_pkg::DEG_SH);

		ev_s5 <= ev_s4;
		fpad_s5 <= fpad_s4;
		deg_s5 <= deg_s4;
		mm_s5 <= 7'(ev_s4.int_v - 20'(deg_s4) * 20'd100);
		spd_s5 <= (spd_raw > 27'(nrmc_pkg::SPEED_SAT)) ? nrmc_pkg::SPEED_SAT : spd_raw[19:0];
		hdg_s5 <= (spd_raw > 27'(nrmc_pkg::HEAD_SAT)) ? nrmc_pkg::HEAD_SAT : spd_raw[16:0];

		ev_s6 <= ev_s5;
		spd_s6 <= spd_s5;
		hdg_s6 <= hdg_s5;
		a_s6 <= (AW'(mm_s5) * AW'(P10F) + AW'(fpad_s5)) * AW'(SCALE);
		dege6_s6 <= 34'(deg_s5) * 34'd1000000;

		ev_s7 <= ev_s6;
		spd_s7 <= spd_s6;
		hdg_s7 <= hdg_s6;
		dege6_s7 <= dege6_s6;
		q_s7 <= QW'(q_prod >> SH);

		ev_s8 <= ev_s7;
		spd_s8 <= spd_s7;
		hdg_s8 <= hdg_s7;
		lat_s8 <= (v_sum > 34'(nrmc_pkg::LAT_SAT)) ? nrmc_pkg::LAT_SAT : v_sum[26:0];
		lon_s8 <= (v_sum > 34'(nrmc_pkg::LON_SAT)) ? nrmc_pkg::LON_SAT : v_sum[29:0];
	end

	// The event leaving the last stage updates the held field values; a line end reports them and then clears them.
	always_comb begin
		tint_n = tint_q;
		tms_n = tms_q;
		lat_n = lat_q;
		lon_n = lon_q;
		spd_n = spd_q;
		hdg_n = hdg_q;
		unique case (ev_s8.fidx)
			nrmc_pkg::FIELD_TIME: begin
				tint_n = ev_s8.int_v;
				tms_n = ev_s8.millis;
			end
			nrmc_pkg::FIELD_LAT: lat_n = lat_s8;
			nrmc_pkg::FIELD_LON: lon_n = lon_s8;
			nrmc_pkg::FIELD_SPEED: spd_n = spd_s8;
			nrmc_pkg::FIELD_COURSE: hdg_n = hdg_s8;
			default: begin
			end
		endcase

		res.sentence_type = ev_s8.stype;
		res.fields_filled = ev_s8.filled;
		if (ev_s8.filled) begin
			res.utc_hhmmss = tint_n;
			res.utc_millis = tms_n;
			res.lat_micro_deg = ev_s8.s_neg ? (28'd0 - {1'b0, lat_n}) : {1'b0, lat_n};
			res.lon_micro_deg = ev_s8.w_neg ? (31'd0 - {1'b0, lon_n}) : {1'b0, lon_n};
			res.speed_centi = spd_n;
			res.heading_centi = hdg_n;
		end else begin
			res.utc_hhmmss = 20'd0;
			res.utc_millis = 10'd0;
			res.lat_micro_deg = 28'sd0;
			res.lon_micro_deg = 31'sd0;
			res.speed_centi = 20'd0;
			res.heading_centi = 17'd0;
		end
		res_valid = v_s8 && ev_s8.lf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tint_q <= 20'd0;
			tms_q <= 10'd0;
			lat_q <= 27'd0;
			lon_q <= 30'd0;
			spd_q <= 20'd0;
			hdg_q <= 17'd0;
		end else if (v_s8) begin
			if (ev_s8.lf) begin
				tint_q <= 20'd0;
				tms_q <= 10'd0;
				lat_q <= 27'd0;
				lon_q <= 30'd0;
				spd_q <= 20'd0;
				hdg_q <= 17'd0;
			end else begin
				tint_q <= tint_n;
				tms_q <= tms_n;
				lat_q <= lat_n;
				lon_q <= lon_n;
				spd_q <= spd_n;
				hdg_q <= hdg_n;
			end
		end
	end

endmodule

@@ rtl/nmea_rmc_sentence_parser.sv @@
`timescale 1ns / 1ps
// Top level of the NMEA RMC sentence parser: handshakes, scanner, conversion pipeline, result queue.
//
// The parser takes one sentence byte per cycle while s_axis_tready is high and emits one result
// for every line feed through a four-entry result queue. Bytes are scanned as they arrive and
// each comma or line feed sends the finished field down a fixed conversion pipeline (reciprocal
// multiplications for the degree split and the minute scaling), so the input never waits for a
// conversion. A line feed reserves a queue entry when it is accepted; the input is held off
// only while four line ends are reserved and not yet taken at the output.
module nmea_rmc_sentence_parser #(
	parameter int FRAC_DIGITS = nrmc_pkg::FRAC_DIGITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // [7:0] char_in
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [1:0] sentence_type, [2] fields_filled, [22:3] utc_hhmmss, [32:23] utc_millis,
	// [60:33] lat_micro_deg, [91:61] lon_micro_deg, [111:92] speed_centi,
	// [128:112] heading_centi, rest zero
	output logic [nrmc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	localparam int PTRW = $clog2(nrmc_pkg::RES_DEPTH);
	localparam int CRW = $clog2(nrmc_pkg::RES_DEPTH + 1);

	logic              in_acc;
	logic              lf_acc;
	logic              out_acc;
	logic              ev_valid;
	nrmc_pkg::event_t  ev;
	logic              res_valid;
	nrmc_pkg::rslt_t   res;

	logic [CRW-1:0]    credit_q;
	logic [CRW-1:0]    fill_q;
	logic [PTRW-1:0]   wr_ptr_q;
	logic [PTRW-1:0]   rd_ptr_q;
	nrmc_pkg::rslt_t   res_mem [nrmc_pkg::RES_DEPTH];

	assign s_axis_tready = credit_q != CRW'(nrmc_pkg::RES_DEPTH);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign lf_acc = in_acc && (s_axis_tdata == nrmc_pkg::CH_LF);
	assign m_axis_tvalid = fill_q != CRW'(0);
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata = nrmc_pkg::OUT_TDATA_W'(res_mem[rd_ptr_q]);

	nrmc_scan #(
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_acc),
		.in_char(s_axis_tdata),
		.ev_valid(ev_valid),
		.ev(ev)
	);

	nrmc_conv #(
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_conv (
		.clk(clk),
		.arst_n(arst_n),
		.ev_valid(ev_valid),
		.ev(ev),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			fill_q <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (lf_acc && !out_acc) begin
				credit_q <= credit_q + CRW'(1);
			end else if (!lf_acc && out_acc) begin
				credit_q <= credit_q - CRW'(1);
			end
			if (res_valid && !out_acc) begin
				fill_q <= fill_q + CRW'(1);
			end else if (!res_valid && out_acc) begin
				fill_q <= fill_q - CRW'(1);
			end
			if (res_valid) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(nrmc_pkg::RES_DEPTH - 1)) ? '0 : wr_ptr_q + PTRW'(1);
			end
			if (out_acc) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(nrmc_pkg::RES_DEPTH - 1)) ? '0 : rd_ptr_q + PTRW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_mem[wr_ptr_q] <= res;
		end
	end

endmodule

@@ rtl/nrmc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker of the NMEA RMC sentence parser, bound to its top level.
module nrmc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [7:0]                       s_axis_tdata,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [nrmc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int RW = nrmc_pkg::RES_W;

	// A stalled result item keeps its place and its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	a_type_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
		else $error("sentence type out of range");

	a_filled_rmc: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == nrmc_pkg::STYPE_RMC)
		else $error("fields filled on a sentence that is not RMC");

	a_unfilled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[RW-1:3] == '0)
		else $error("values reported on an unfilled sentence");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[nrmc_pkg::OUT_TDATA_W-1:RW] == '0)
		else $error("padding bits of the result item are not zero");

endmodule

bind nmea_rmc_sentence_parser nrmc_checker u_nrmc_checker (.*);
